[rtl/positional_list_insert_delete_assert.svh]
// Assertion macros for the positional list block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH

// Same-cycle implication.
`define PLIST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("plist assertion failed");

// Next-cycle implication.
`define PLIST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("plist assertion failed");

`endif

[rtl/plist_pkg.sv]
// Package for the positional list block: operation codes and cell controls.
// No dependencies.
`default_nettype none

package plist_pkg;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_INSERT = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

  // Per-transaction cell controls, already qualified by success.
  typedef struct packed {
    logic append;
    logic del;
    logic ins;
    logic rd;
  } cell_op_t;

  // Cells per first-level read group.
  localparam int unsigned ReadGroup = 16;

endpackage

`default_nettype wire

[rtl/plist_cell.sv]
// One storage cell of the list chain: holds a single entry.
// Depends on plist_pkg.
`default_nettype none

module plist_cell
  import plist_pkg::*;
#(
  parameter int unsigned INDEX = 0,
  parameter int unsigned IDX_W = 8
) (
  input  wire logic             clk_i,
  input  wire cell_op_t         op_i,
  input  wire logic [IDX_W-1:0] pos_idx_i,
  input  wire logic [IDX_W-1:0] cnt_idx_i,
  input  wire logic [31:0]      value_i,
  input  wire logic [31:0]      left_i,
  input  wire logic [31:0]      right_i,
  output logic      [31:0]      entry_o,
  output logic      [31:0]      rd_o
);

  localparam logic [IDX_W-1:0] IdxC = IDX_W'(INDEX);

  logic [31:0] entry_d, entry_q;

  always_comb begin
    entry_d = entry_q;
    if (op_i.append && (cnt_idx_i == IdxC)) begin
      entry_d = value_i;
    end
    if (op_i.del && (pos_idx_i <= IdxC)) begin
      entry_d = right_i;
    end
    if (op_i.ins) begin
      if (pos_idx_i == IdxC) begin
        entry_d = value_i;
      end else if (pos_idx_i < IdxC) begin
        entry_d = left_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign rd_o    = (op_i.rd && (pos_idx_i == IdxC)) ? entry_q : 32'd0;

endmodule

`default_nettype wire

[rtl/positional_list_insert_delete.sv]
// Positional list, top level: chain of plist_cell entries, fill count,
// two-level registered read tree and output register.
// Depends on plist_pkg, plist_cell and positional_list_insert_delete_assert.svh.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit entries with
// one-based positions. Append, delete, insert and read each give one result
// transaction. Every cell updates in the accepting cycle, with neighbours
// shifting one place for delete and insert, so one transaction is accepted
// per cycle while the input is not stalled. Acceptance loads the first read
// stage (group ORs of ReadGroup cells); when that stage advances, the output
// register is loaded after the final OR across groups and presents the
// result. A result held in the output register stalls the read stage,
// and a held read stage stalls the input.
`default_nettype none

`include "positional_list_insert_delete_assert.svh"

module positional_list_insert_delete
  import plist_pkg::*;
#(
  parameter int unsigned CAPACITY = 256,
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1),
  localparam int unsigned IDX_W = $clog2(CAPACITY)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         func_i,
  input  wire logic [CNT_W-1:0]   position_i,
  input  wire logic signed [31:0] value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    ok_o,
  output logic signed [31:0]      read_value_o,
  output logic [CNT_W-1:0]        entry_count_o,
  output logic                    is_empty_o,
  output logic                    is_full_o
);

  localparam int unsigned NGroup = (CAPACITY + ReadGroup - 1) / ReadGroup;
  localparam logic [CNT_W-1:0] CapC = CNT_W'(CAPACITY);

  func_e            func;
  logic             in_fire, s1_go;
  logic             pos_ok, not_full, ok_d;
  logic [CNT_W-1:0] count_d, count_q, pos_m1;
  logic [IDX_W-1:0] pos_idx, cnt_idx;
  cell_op_t         op;

  logic [31:0] entry [CAPACITY];
  logic [31:0] rd    [CAPACITY];

  logic             s1_valid_q, s1_ok_q;
  logic [CNT_W-1:0] s1_count_q;
  logic [31:0]      grp_d [NGroup];
  logic [31:0]      grp_q [NGroup];
  logic [31:0]      rd_all;

  logic             out_valid_q, ok_q, empty_q, full_q;
  logic [31:0]      rdv_q;
  logic [CNT_W-1:0] out_count_q;

  assign func     = func_e'(func_i);
  assign s1_go    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_fire  = in_valid_i && in_ready_o;

  assign pos_ok   = (position_i != '0) && (position_i <= count_q);
  assign not_full = count_q < CapC;
  assign pos_m1   = position_i - CNT_W'(1);
  assign pos_idx  = pos_m1[IDX_W-1:0];
  assign cnt_idx  = count_q[IDX_W-1:0];

  always_comb begin
    ok_d    = 1'b0;
    count_d = count_q;
    op      = '0;
    case (func)
      FUNC_APPEND: begin
        ok_d      = not_full;
        op.append = in_fire && not_full;
        if (op.append) count_d = count_q + CNT_W'(1);
      end
      FUNC_DELETE: begin
        ok_d   = pos_ok;
        op.del = in_fire && pos_ok;
        if (op.del) count_d = count_q - CNT_W'(1);
      end
      FUNC_INSERT: begin
        ok_d   = not_full && pos_ok;
        op.ins = in_fire && not_full && pos_ok;
        if (op.ins) count_d = count_q + CNT_W'(1);
      end
      FUNC_READ: begin
        ok_d  = pos_ok;
        op.rd = in_fire && pos_ok;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    plist_cell #(
      .INDEX (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk_i     (clk_i),
      .op_i      (op),
      .pos_idx_i (pos_idx),
      .cnt_idx_i (cnt_idx),
      .value_i   (value_i),
      .left_i    ((i == 0) ? entry[0] : entry[(i == 0) ? 0 : i - 1]),
      .right_i   ((i == CAPACITY - 1) ? entry[i] : entry[(i == CAPACITY - 1) ? i : i + 1]),
      .entry_o   (entry[i]),
      .rd_o      (rd[i])
    );
  end

  always_comb begin
    for (int g = 0; g < NGroup; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < ReadGroup; k++) begin
        if (g * ReadGroup + k < CAPACITY) begin
          grp_d[g] = grp_d[g] | rd[g * ReadGroup + k];
        end
      end
    end
  end

  always_comb begin
    rd_all = '0;
    for (int g = 0; g < NGroup; g++) begin
      rd_all = rd_all | grp_q[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ok_q    <= ok_d;
      s1_count_q <= count_d;
      grp_q      <= grp_d;
    end
    if (s1_go) begin
      ok_q        <= s1_ok_q;
      rdv_q       <= rd_all;
      out_count_q <= s1_count_q;
      empty_q     <= (s1_count_q == '0);
      full_q      <= (s1_count_q == CapC);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_q;
  assign read_value_o  = rdv_q;
  assign entry_count_o = out_count_q;
  assign is_empty_o    = empty_q;
  assign is_full_o     = full_q;

  `PLIST_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CapC)
  `PLIST_ASSERT_NEXT(a_fail_keeps_count, in_fire && !ok_d, $stable(count_q))
  `PLIST_ASSERT_NOW(a_flags_exclusive, out_valid_q, !(is_empty_o && is_full_o))
  `PLIST_ASSERT_NEXT(a_stage_stall, s1_valid_q && !s1_go, s1_valid_q && $stable(s1_count_q))

endmodule

`default_nettype wire
